// ===== rtl/assert_macros.svh =====
// assertion macros shared by the histogram rtl
// expects clk and rst_n in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define MHC_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("histogram check failed");

// next-cycle implication, off during reset
`define MHC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("histogram check failed");

`endif

// ===== rtl/mhc_pkg.sv =====
// shared types and constants of the masked histogram counter
// no dependencies
`default_nettype none

package mhc_pkg;

    localparam int COUNT_W = 32;
    localparam int INDEX_W = 16;
    localparam int BOUND_W = 9;
    localparam int EPOCH_W = 4;

    localparam logic [BOUND_W-1:0] BINS_IN_USE_RESET = 9'd256;
    localparam logic [EPOCH_W-1:0] EPOCH_LAST = '1;

    typedef enum logic [2:0] {
        OP_CLEAR        = 3'd0,
        OP_SET_PRESENCE = 3'd1,
        OP_COUNT        = 3'd2,
        OP_MERGE        = 3'd3,
        OP_READ         = 3'd4
    } op_t;

    typedef struct packed {
        logic active;
        logic wipe_flags;
    } sweep_t;

endpackage

`default_nettype wire

// ===== rtl/masked_histogram_counter.sv =====
// masked histogram counter: transfer loads stage 1 and ram read, then the result register
// one item per cycle unless stalled; back-to-back same-bin hits forwarded from write port
// counter memory holds {epoch, count}; a clear bumps the epoch
// clearing pass over every bin after reset and on every 16th clear, no input taken then
// reset: rst_n asynchronous active low, bins_in_use 256, all bins absent and zero
// depends on mhc_pkg, mhc_ram, mhc_sweep, assert_macros.svh
`default_nettype none

`include "assert_macros.svh"

module masked_histogram_counter
    import mhc_pkg::*;
#(
    parameter int NUM_BINS = 256
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic [BOUND_W-1:0] bins_in_use,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         operation,
    input  wire logic [INDEX_W-1:0] bin_index,
    input  wire logic               present_flag,
    input  wire logic [COUNT_W-1:0] addend,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic      [COUNT_W-1:0] bin_count,
    output logic                    accepted
);

    localparam int AW = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;
    localparam int WORD_W = EPOCH_W + COUNT_W;
    localparam logic [INDEX_W-1:0] NB_IDX = INDEX_W'(NUM_BINS);

    logic [BOUND_W-1:0] bins_in_use_reg;

    logic               s1_valid_reg;
    logic [2:0]         s1_op_reg;
    logic [INDEX_W-1:0] s1_idx_reg;
    logic               s1_flag_reg;
    logic [COUNT_W-1:0] s1_add_reg;
    logic               fwd_cnt_hit_reg;
    logic [WORD_W-1:0]  fwd_cnt_word_reg;
    logic               fwd_prs_hit_reg;
    logic               fwd_prs_reg;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] bin_count_reg;
    logic               accepted_reg;

    sweep_t             sweep_st;
    logic [AW-1:0]      sweep_addr;
    logic [EPOCH_W-1:0] epoch;

    logic               in_xfer;
    logic               s1_fire;
    logic               clear_fire;
    logic               wrap_hold;
    logic [INDEX_W-1:0] bound;
    logic               in_range;
    logic [WORD_W-1:0]  cnt_q;
    logic [WORD_W-1:0]  cnt_cur;
    logic [COUNT_W-1:0] cur_val;
    logic [COUNT_W-1:0] upd_val;
    logic               prs_q;
    logic               prs_cur;
    logic               do_cnt_write;
    logic               do_prs_write;
    logic [COUNT_W-1:0] res_count;
    logic               res_ok;

    logic               cnt_we;
    logic [AW-1:0]      cnt_waddr;
    logic [WORD_W-1:0]  cnt_wdata;
    logic               prs_we;
    logic [AW-1:0]      prs_waddr;
    logic               prs_wdata;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bins_in_use_reg <= BINS_IN_USE_RESET;
        end
        else if (cfg_we)
        begin
            bins_in_use_reg <= bins_in_use;
        end
    end

    assign s1_fire    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign clear_fire = s1_fire && (s1_op_reg == OP_CLEAR);
    // a clear that wraps the epoch starts a pass; keep new reads out until it is done
    assign wrap_hold  = s1_valid_reg && (s1_op_reg == OP_CLEAR) && (epoch == EPOCH_LAST);
    assign in_ready   = !sweep_st.active && !wrap_hold && (!s1_valid_reg || s1_fire);
    assign in_xfer    = in_valid && in_ready;

    mhc_sweep #(
        .NUM_BINS (NUM_BINS),
        .AW       (AW)
    ) u_sweep (
        .clk        (clk),
        .rst_n      (rst_n),
        .clear_fire (clear_fire),
        .sweep      (sweep_st),
        .addr       (sweep_addr),
        .epoch      (epoch)
    );

    mhc_ram #(
        .WIDTH (WORD_W),
        .DEPTH (NUM_BINS),
        .AW    (AW)
    ) u_count_ram (
        .clk   (clk),
        .we    (cnt_we),
        .waddr (cnt_waddr),
        .wdata (cnt_wdata),
        .re    (in_xfer),
        .raddr (bin_index[AW-1:0]),
        .rdata (cnt_q)
    );

    mhc_ram #(
        .WIDTH (1),
        .DEPTH (NUM_BINS),
        .AW    (AW)
    ) u_present_ram (
        .clk   (clk),
        .we    (prs_we),
        .waddr (prs_waddr),
        .wdata (prs_wdata),
        .re    (in_xfer),
        .raddr (bin_index[AW-1:0]),
        .rdata (prs_q)
    );

    // execute stage
    always_comb
    begin
        bound = ({7'd0, bins_in_use_reg} < NB_IDX) ? {7'd0, bins_in_use_reg} : NB_IDX;
        in_range = s1_idx_reg < bound;
        cnt_cur = fwd_cnt_hit_reg ? fwd_cnt_word_reg : cnt_q;
        prs_cur = fwd_prs_hit_reg ? fwd_prs_reg : prs_q;
        // stale epoch means the bin was cleared
        cur_val = (cnt_cur[COUNT_W +: EPOCH_W] == epoch) ? cnt_cur[COUNT_W-1:0] : '0;
        upd_val = cur_val;
        do_cnt_write = 1'b0;
        do_prs_write = 1'b0;
        res_count = '0;
        res_ok = 1'b0;
        unique case (s1_op_reg)
            OP_CLEAR:
            begin
                res_ok = 1'b1;
            end
            OP_SET_PRESENCE:
            begin
                if (in_range)
                begin
                    do_prs_write = 1'b1;
                    res_ok = 1'b1;
                    res_count = cur_val;
                end
            end
            OP_COUNT:
            begin
                if (in_range)
                begin
                    upd_val = cur_val + COUNT_W'(1);
                    if (prs_cur)
                    begin
                        do_cnt_write = 1'b1;
                        res_ok = 1'b1;
                        res_count = upd_val;
                    end
                    else
                    begin
                        res_count = cur_val;
                    end
                end
            end
            OP_MERGE:
            begin
                if (in_range)
                begin
                    upd_val = cur_val + s1_add_reg;
                    do_cnt_write = 1'b1;
                    res_ok = 1'b1;
                    res_count = upd_val;
                end
            end
            OP_READ:
            begin
                if (in_range)
                begin
                    res_ok = 1'b1;
                    res_count = cur_val;
                end
            end
            default:
            begin
                res_ok = 1'b0;
            end
        endcase
    end

    // write ports: pass sweep or execute stage, never both
    always_comb
    begin
        if (sweep_st.active)
        begin
            cnt_we    = 1'b1;
            cnt_waddr = sweep_addr;
            cnt_wdata = {epoch, {COUNT_W{1'b0}}};
            prs_we    = sweep_st.wipe_flags;
            prs_waddr = sweep_addr;
            prs_wdata = 1'b0;
        end
        else
        begin
            cnt_we    = s1_fire && do_cnt_write;
            cnt_waddr = s1_idx_reg[AW-1:0];
            cnt_wdata = {epoch, upd_val};
            prs_we    = s1_fire && do_prs_write;
            prs_waddr = s1_idx_reg[AW-1:0];
            prs_wdata = s1_flag_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_xfer)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (s1_fire)
            begin
                s1_valid_reg <= 1'b0;
            end

            if (s1_fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            s1_op_reg   <= operation;
            s1_idx_reg  <= bin_index;
            s1_flag_reg <= present_flag;
            s1_add_reg  <= addend;
            // the ram read misses a write done on the same edge, so keep it aside
            fwd_cnt_hit_reg  <= cnt_we && (cnt_waddr == bin_index[AW-1:0]);
            fwd_cnt_word_reg <= cnt_wdata;
            fwd_prs_hit_reg  <= prs_we && (prs_waddr == bin_index[AW-1:0]);
            fwd_prs_reg      <= prs_wdata;
        end
        if (s1_fire)
        begin
            bin_count_reg <= res_count;
            accepted_reg  <= res_ok;
        end
    end

    assign out_valid = out_valid_reg;
    assign bin_count = bin_count_reg;
    assign accepted  = accepted_reg;

    `MHC_ASSERT_SAME(a_no_exec_in_sweep, sweep_st.active, !s1_valid_reg)
    `MHC_ASSERT_NEXT(a_wrap_starts_sweep, clear_fire && (epoch == EPOCH_LAST), sweep_st.active)
    `MHC_ASSERT_NEXT(a_xfer_fills_stage, in_xfer, s1_valid_reg)

endmodule

`default_nettype wire

// ===== rtl/mhc_ram.sv =====
// single-port-write, single-port-read synchronous memory with a registered, enabled read
// no dependencies
`default_nettype none

module mhc_ram #(
    parameter int WIDTH = 36,
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/mhc_sweep.sv =====
// clearing pass sequencer and clear epoch for the counter memory
// depends on mhc_pkg
`default_nettype none

module mhc_sweep
    import mhc_pkg::*;
#(
    parameter int NUM_BINS = 256,
    parameter int AW       = 8
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               clear_fire,
    output sweep_t                  sweep,
    output logic      [AW-1:0]      addr,
    output logic      [EPOCH_W-1:0] epoch
);

    localparam logic [AW-1:0] LAST_ADDR = AW'(NUM_BINS - 1);

    logic               active_reg;
    logic               wipe_reg;
    logic [AW-1:0]      addr_reg;
    logic [EPOCH_W-1:0] epoch_reg;

    // reset pass wipes presence too; epoch wrap pass only rewrites counters
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b1;
            wipe_reg   <= 1'b1;
            addr_reg   <= '0;
            epoch_reg  <= '0;
        end
        else
        begin
            if (active_reg)
            begin
                addr_reg <= addr_reg + AW'(1);
                if (addr_reg == LAST_ADDR)
                begin
                    active_reg <= 1'b0;
                    wipe_reg   <= 1'b0;
                end
            end
            else if (clear_fire)
            begin
                epoch_reg <= epoch_reg + EPOCH_W'(1);
                if (epoch_reg == EPOCH_LAST)
                begin
                    active_reg <= 1'b1;
                    addr_reg   <= '0;
                end
            end
        end
    end

    assign sweep.active     = active_reg;
    assign sweep.wipe_flags = wipe_reg;
    assign addr             = addr_reg;
    assign epoch            = epoch_reg;

endmodule

`default_nettype wire
